// ===== design/gww_pkg.sv =====
// Shared types and constants for the greedy word-wrap block.
// Holds the command format that passes from the front end to the back end.
// No dependencies.
`default_nettype none

package gww_pkg;

  localparam int unsigned CmdIdxW    = 5;
  localparam int unsigned CmdCntW    = 6;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned CfgIdxW    = 8;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;

  localparam logic [CfgIdxW-1:0] CfgLineWidth  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTabColumns = 8'd1;

  localparam logic [7:0] LineWidthRst  = 8'd30;
  localparam logic [3:0] TabColumnsRst = 4'd4;

  typedef struct packed {
    logic               pre_nl;
    logic               wr_en;
    logic [CmdIdxW-1:0] wr_idx;
    logic [7:0]         wr_char;
    logic [CmdCntW-1:0] flush_len;
    logic               tail_nl;
    logic [3:0]         tail_spaces;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/gww_front.sv =====
// Front end of the word-wrap block: configuration registers, line and word
// tracking, and translation of each input byte into one command.
// Depends on gww_pkg.
`default_nettype none

module gww_front import gww_pkg::*; #(
  parameter int unsigned WORD_DEPTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         ch_i,
  input  wire logic               end_i,
  output logic                    cmd_valid_o,
  input  wire logic               cmd_ready_i,
  output cmd_t                    cmd_o
);

  localparam int unsigned CntW = $clog2(WORD_DEPTH + 1);

  logic [7:0]      width_q, width_eff;
  logic [3:0]      tab_q, tab_eff, ws;
  logic [7:0]      line_q, line_d;
  logic            in_word_q, in_word_d;
  logic            wbl_q, wbl_d, wbl_cur;
  logic [CntW-1:0] wc_q, wc_d, wc_inc;
  logic [8:0]      next_col;
  logic            is_ws, accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i & cmd_ready_i;

  always_comb begin
    cmd_o     = '0;
    line_d    = line_q;
    in_word_d = in_word_q;
    wbl_d     = wbl_q;
    wc_d      = wc_q;
    wbl_cur   = wbl_q;
    ws        = 4'd1;
    next_col  = '0;
    wc_inc    = wc_q + CntW'(1);
    width_eff = (width_q == 8'd0) ? 8'd1 : width_q;
    if (tab_q == 4'd0) begin
      tab_eff = 4'd1;
    end else if (tab_q > 4'd8) begin
      tab_eff = 4'd8;
    end else begin
      tab_eff = tab_q;
    end
    is_ws = (ch_i == ChSpace) || (ch_i == ChTab) || (ch_i == ChNl);

    if (end_i || is_ws) begin
      cmd_o.flush_len = in_word_q ? CmdCntW'(wc_q) : '0;
      in_word_d = 1'b0;
      wbl_d     = 1'b0;
      wc_d      = '0;
      if (!end_i) begin
        if (ch_i == ChNl) begin
          cmd_o.tail_nl = 1'b1;
          line_d        = 8'd0;
        end else begin
          ws       = (ch_i == ChTab) ? tab_eff : 4'd1;
          next_col = {1'b0, line_q} + 9'(ws);
          if (next_col > {1'b0, width_eff}) begin
            cmd_o.tail_nl = 1'b1;
            line_d        = 8'd0;
          end else begin
            cmd_o.tail_spaces = ws;
            line_d = next_col[8] ? 8'hFF : next_col[7:0];
          end
        end
      end
    end else begin
      wbl_cur   = in_word_q ? wbl_q : (line_q == 8'd0);
      in_word_d = 1'b1;
      next_col  = {1'b0, line_q} + 9'd1;
      if ((next_col > {1'b0, width_eff}) && !wbl_cur) begin
        cmd_o.pre_nl = 1'b1;
        line_d       = 8'(wc_q) + 8'd1;
        wbl_d        = 1'b1;
      end else begin
        line_d = next_col[8] ? 8'hFF : next_col[7:0];
        wbl_d  = wbl_cur;
      end
      cmd_o.wr_en   = 1'b1;
      cmd_o.wr_idx  = CmdIdxW'(wc_q);
      cmd_o.wr_char = ch_i;
      if (wc_inc == CntW'(WORD_DEPTH)) begin
        cmd_o.flush_len = CmdCntW'(wc_inc);
        wc_d = '0;
      end else begin
        wc_d = wc_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= LineWidthRst;
      tab_q     <= TabColumnsRst;
      line_q    <= '0;
      in_word_q <= 1'b0;
      wbl_q     <= 1'b0;
      wc_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgLineWidth) begin
          width_q <= cfg_data_i;
        end else if (cfg_index_i == CfgTabColumns) begin
          tab_q <= cfg_data_i[3:0];
        end
      end
      if (accept) begin
        line_q    <= line_d;
        in_word_q <= in_word_d;
        wbl_q     <= wbl_d;
        wc_q      <= wc_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gww_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on gww_pkg.
`default_nettype none

module gww_fifo import gww_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_data_o
);

  cmd_t                 slots_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q != (QueuePtrW + 1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (QueuePtrW + 1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (QueuePtrW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gww_back.sv =====
// Back end of the word-wrap block: word store and output sequencer that
// carries out one command at a time into a registered output stage.
// Depends on gww_pkg.
`default_nettype none

module gww_back import gww_pkg::*; #(
  parameter int unsigned WORD_DEPTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  input  wire cmd_t  cmd_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  localparam int unsigned CntW = $clog2(WORD_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(WORD_DEPTH);

  typedef enum logic [1:0] {StIdle, StPre, StFlush, StTail} state_e;

  state_e          state_q;
  cmd_t            cmd_q;
  logic [CntW-1:0] idx_q, idx_d, flen;
  logic [3:0]      sp_q;
  logic            out_valid_q, out_last_q;
  logic [7:0]      out_char_q;
  logic [7:0]      mem [WORD_DEPTH];
  logic [7:0]      rd_q;
  logic            pop, can_load, has_flush, has_tail, last_byte, out_load;

  assign cmd_ready_o = (state_q == StIdle);
  assign pop         = cmd_valid_i & cmd_ready_o;
  assign can_load    = !out_valid_q || out_ready_i;
  assign out_load    = can_load && (state_q != StIdle);
  assign flen        = cmd_q.flush_len[CntW-1:0];
  assign has_flush   = (flen != '0);
  assign has_tail    = cmd_q.tail_nl || (cmd_q.tail_spaces != 4'd0);
  assign last_byte   = ((idx_q + CntW'(1)) == flen);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    idx_d = idx_q;
    if (pop) begin
      idx_d = '0;
    end else if ((state_q == StFlush) && can_load && !last_byte) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.wr_en) begin
      mem[cmd_i.wr_idx[IdxW-1:0]] <= cmd_i.wr_char;
    end
    rd_q <= mem[idx_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      idx_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (pop) begin
            cmd_q <= cmd_i;
            sp_q  <= cmd_i.tail_spaces;
            if (cmd_i.pre_nl) begin
              state_q <= StPre;
            end else if (cmd_i.flush_len != '0) begin
              state_q <= StFlush;
            end else if (cmd_i.tail_nl || (cmd_i.tail_spaces != 4'd0)) begin
              state_q <= StTail;
            end
          end
        end
        StPre: begin
          if (can_load) begin
            out_char_q  <= ChNl;
            out_last_q  <= !has_flush && !has_tail;
            if (has_flush) begin
              state_q <= StFlush;
            end else if (has_tail) begin
              state_q <= StTail;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StFlush: begin
          if (can_load) begin
            out_char_q  <= rd_q;
            out_last_q  <= last_byte && !has_tail;
            if (last_byte) begin
              state_q <= has_tail ? StTail : StIdle;
            end
          end
        end
        StTail: begin
          if (can_load) begin
            if (cmd_q.tail_nl) begin
              out_char_q <= ChNl;
              out_last_q <= 1'b1;
              state_q    <= StIdle;
            end else begin
              out_char_q <= ChSpace;
              out_last_q <= (sp_q == 4'd1);
              sp_q       <= sp_q - 4'd1;
              if (sp_q == 4'd1) begin
                state_q <= StIdle;
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/greedy_word_wrap_top.sv =====
// Greedy word-wrap engine: top level joining front end, command queue and
// back end. Depends on gww_pkg, gww_front, gww_fifo and gww_back.
//
// Each accepted byte becomes one command in a four-entry queue; the front end
// takes a byte in every cycle while the queue has room. The back end takes a
// command only while idle and then emits its bytes through its output
// sequencer, taking no new command until the last byte has been loaded.
// Word bytes are held in a WORD_DEPTH-entry store read one byte per cycle
// during a flush while the output is not stalled. The end
// flag (tlast on the input) flushes the pending word, and tlast on the
// output marks the final result of each input item.
`default_nettype none

module greedy_word_wrap_top import gww_pkg::*; #(
  parameter int unsigned WORD_DEPTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,  // [7:0] ch
  input  wire logic               s_axis_tlast,  // end_of_text
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [7:0]              m_axis_tdata,  // [7:0] out_char
  output logic                    m_axis_tlast   // last
);

  logic cmd_push_valid, cmd_push_ready, cmd_pop_valid, cmd_pop_ready;
  cmd_t cmd_push, cmd_pop;

  gww_front #(.WORD_DEPTH(WORD_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .ch_i        (s_axis_tdata),
    .end_i       (s_axis_tlast),
    .cmd_valid_o (cmd_push_valid),
    .cmd_ready_i (cmd_push_ready),
    .cmd_o       (cmd_push)
  );

  gww_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push_valid),
    .push_ready_o (cmd_push_ready),
    .push_data_i  (cmd_push),
    .pop_valid_o  (cmd_pop_valid),
    .pop_ready_i  (cmd_pop_ready),
    .pop_data_o   (cmd_pop)
  );

  gww_back #(.WORD_DEPTH(WORD_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_pop_valid),
    .cmd_ready_o (cmd_pop_ready),
    .cmd_i       (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
